### rtl/core/irpd_pkg.sv
// Shared types and constants for the IR pulse-distance bit decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int THRESH_WIDTH        = 16;
    localparam int SYM_WIDTH           = 2;
    localparam int PHASE_WIDTH         = 3;
    localparam int CFG_INDEX_WIDTH     = 2;

    // phase codes
    localparam logic [PHASE_WIDTH-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_LEADER = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_GAP    = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_WAITHI = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] PH_FIRST  = 3'd4;
    localparam logic [PHASE_WIDTH-1:0] PH_SECOND = 3'd5;

    // symbol codes
    localparam logic [SYM_WIDTH-1:0] SYM_ZERO = 2'd0;
    localparam logic [SYM_WIDTH-1:0] SYM_ONE  = 2'd1;
    localparam logic [SYM_WIDTH-1:0] SYM_END  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEADER_GAP    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRST_SAMPLE  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SECOND_SAMPLE = 2'd2;

    // register reset values
    localparam logic [THRESH_WIDTH-1:0] LEADER_GAP_RESET    = 16'd9000;
    localparam logic [THRESH_WIDTH-1:0] FIRST_SAMPLE_RESET  = 16'd1125;
    localparam logic [THRESH_WIDTH-1:0] SECOND_SAMPLE_RESET = 16'd2250;

    typedef struct packed {
        logic [THRESH_WIDTH-1:0] leader_gap_ticks;
        logic [THRESH_WIDTH-1:0] first_sample_ticks;
        logic [THRESH_WIDTH-1:0] second_sample_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        logic [SYM_WIDTH-1:0] symbol;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/irpd_cfg_regs.sv
// Configuration register bank of the IR pulse-distance bit decoder.
// Depends on irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpd_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [irpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [irpd_pkg::THRESH_WIDTH-1:0]    cfg_data,
    output irpd_pkg::cfg_t                            cfg
);

    irpd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leader_gap_ticks    <= irpd_pkg::LEADER_GAP_RESET;
            cfg_reg.first_sample_ticks  <= irpd_pkg::FIRST_SAMPLE_RESET;
            cfg_reg.second_sample_ticks <= irpd_pkg::SECOND_SAMPLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                irpd_pkg::REG_LEADER_GAP:    cfg_reg.leader_gap_ticks    <= cfg_data;
                irpd_pkg::REG_FIRST_SAMPLE:  cfg_reg.first_sample_ticks  <= cfg_data;
                irpd_pkg::REG_SECOND_SAMPLE: cfg_reg.second_sample_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/core/irpd_fsm.sv
// Phase sequencer and saturating delay counter; one line sample per transaction.
// Depends on irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpd_fsm #(
    parameter int COUNT_WIDTH = irpd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire irpd_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    input  wire logic          line_level,
    output irpd_pkg::result_t  result
);

    localparam int CmpW = (COUNT_WIDTH > irpd_pkg::THRESH_WIDTH) ?
                          COUNT_WIDTH : irpd_pkg::THRESH_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

    logic [irpd_pkg::PHASE_WIDTH-1:0] phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]           cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0]           cnt_inc;
    logic [irpd_pkg::THRESH_WIDTH-1:0] thresh;
    logic                             done;
    irpd_pkg::result_t                res;

    assign cnt_inc = (cnt_reg == CntMax) ? cnt_reg : cnt_reg + 1'b1;

    always_comb
    begin
        case (phase_reg)
            irpd_pkg::PH_FIRST:  thresh = cfg.first_sample_ticks;
            irpd_pkg::PH_SECOND: thresh = cfg.second_sample_ticks;
            default:             thresh = cfg.leader_gap_ticks;
        endcase
    end

    assign done = (CmpW'(cnt_inc) >= CmpW'(thresh)) || (cnt_inc == CntMax);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        res.valid  = 1'b0;
        res.symbol = irpd_pkg::SYM_ZERO;
        case (phase_reg)
            irpd_pkg::PH_LEADER:
            begin
                if (line_level)
                begin
                    cnt_next   = '0;
                    phase_next = irpd_pkg::PH_GAP;
                end
            end
            irpd_pkg::PH_GAP:
            begin
                cnt_next = cnt_inc;
                if (done)
                begin
                    phase_next = irpd_pkg::PH_WAITHI;
                    if (line_level)
                    begin
                        cnt_next   = '0;
                        phase_next = irpd_pkg::PH_FIRST;
                    end
                end
            end
            irpd_pkg::PH_WAITHI:
            begin
                if (line_level)
                begin
                    cnt_next   = '0;
                    phase_next = irpd_pkg::PH_FIRST;
                end
            end
            irpd_pkg::PH_FIRST:
            begin
                cnt_next = cnt_inc;
                if (done)
                begin
                    if (!line_level)
                    begin
                        phase_next = irpd_pkg::PH_WAITHI;
                        res.valid  = 1'b1;
                        res.symbol = irpd_pkg::SYM_ZERO;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        phase_next = irpd_pkg::PH_SECOND;
                    end
                end
            end
            irpd_pkg::PH_SECOND:
            begin
                cnt_next = cnt_inc;
                if (done)
                begin
                    res.valid = 1'b1;
                    if (!line_level)
                    begin
                        phase_next = irpd_pkg::PH_WAITHI;
                        res.symbol = irpd_pkg::SYM_ONE;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        phase_next = irpd_pkg::PH_IDLE;
                        res.symbol = irpd_pkg::SYM_END;
                    end
                end
            end
            default:
            begin
                phase_next = irpd_pkg::PH_IDLE;
                if (!line_level)
                begin
                    cnt_next   = '0;
                    phase_next = irpd_pkg::PH_LEADER;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= irpd_pkg::PH_IDLE;
            cnt_reg   <= '0;
        end
        else if (in_valid)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign result.valid  = in_valid & res.valid;
    assign result.symbol = res.symbol;

`ifndef SYNTHESIS
    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.symbol == irpd_pkg::SYM_END) |=>
        (phase_reg == irpd_pkg::PH_IDLE && cnt_reg == '0))
        else $error("end of frame did not return to idle");
    a_bit_to_waithi: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.symbol != irpd_pkg::SYM_END) |=>
        (phase_reg == irpd_pkg::PH_WAITHI))
        else $error("bit symbol did not return to wait-for-high");
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |=> ($stable(phase_reg) && $stable(cnt_reg)))
        else $error("state changed without a transaction");
    a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
        (phase_reg == irpd_pkg::PH_FIRST || phase_reg == irpd_pkg::PH_SECOND))
        else $error("symbol emitted outside a sample phase");
`endif

endmodule

`default_nettype wire

### rtl/core/irpd_out_queue.sv
// Two-entry result queue that decouples the decoder from a stalling receiver.
// Depends on irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpd_out_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire irpd_pkg::result_t              push,
    output logic                                full,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [irpd_pkg::SYM_WIDTH-1:0]      out_symbol
);

    logic [irpd_pkg::SYM_WIDTH-1:0] slot_reg [2];
    logic                           wr_ptr_reg, wr_ptr_next;
    logic                           rd_ptr_reg, rd_ptr_next;
    logic [1:0]                     cnt_reg, cnt_next;
    logic                           pop;

    assign pop        = out_valid & out_ready;
    assign out_valid  = (cnt_reg != 2'd0);
    assign full       = (cnt_reg == 2'd2);
    assign out_symbol = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.symbol;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push.valid)
        else $error("push into full result queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");
    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("result queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

### rtl/core/ir_pulse_distance_bit_decoder.sv
// Top level of the IR pulse-distance bit decoder (NEC-style timing).
// Depends on irpd_pkg, irpd_cfg_regs, irpd_fsm and irpd_out_queue.
//
// Usage:
//   Slave stream s_*: one sample of the active-low receiver line per
//   transaction (s_tdata[0]); 0 is a mark, 1 is idle.
//   Master stream m_*: one decoded symbol per transaction (m_tdata[1:0]):
//   0 bit zero, 1 bit one, 2 end of frame. Most samples give no symbol.
//   Config port: cfg_we/cfg_index/cfg_data write the leader gap (0),
//   first sample (1) and second sample (2) delays in samples; other
//   indexes are ignored. Write only while the block is idle.
//   Throughput: one sample per cycle while s_tready is high; the phase and
//   saturating counter update on each accepted sample. Output: a symbol is
//   written into the registered result queue when its sample is accepted.
//   Stall: results wait in a two-entry queue; s_tready drops only while
//   both entries are occupied and comes back as soon as one is taken.
//   Reset: rst_n is asynchronous, active low; the block returns to idle,
//   the queue empties and the delay registers take their default values
//   (9000, 1125, 2250 samples).
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_distance_bit_decoder #(
    parameter int COUNT_WIDTH = irpd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [7:0]                           s_tdata,  // [0] line_level
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [7:0]                                m_tdata,  // [1:0] symbol
    input  wire logic                                 cfg_we,
    input  wire logic [irpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [irpd_pkg::THRESH_WIDTH-1:0]    cfg_data
);

    irpd_pkg::cfg_t                 cfg;
    irpd_pkg::result_t              result;
    logic                           q_full;
    logic                           in_fire;
    logic [irpd_pkg::SYM_WIDTH-1:0] symbol;

    assign s_tready = ~q_full;
    assign in_fire  = s_tvalid & s_tready;

    irpd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    irpd_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_fire),
        .line_level (s_tdata[0]),
        .result     (result)
    );

    irpd_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (result),
        .full       (q_full),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_symbol (symbol)
    );

    assign m_tdata = {{(8 - irpd_pkg::SYM_WIDTH){1'b0}}, symbol};

endmodule

`default_nettype wire

### sim/irpd_checker.sv
// Scoreboard for the IR pulse-distance bit decoder: tracks the line samples,
// delay register writes and symbols on the ports, and flags any mismatch.
// Depends on irpd_pkg.
`timescale 1ns / 1ps

module irpd_checker #(
    parameter int COUNT_WIDTH = irpd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    input  wire logic                                 s_tready,
    input  wire logic [7:0]                           s_tdata,  // [0] line_level
    input  wire logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic [7:0]                           m_tdata,  // [1:0] symbol
    input  wire logic                                 cfg_we,
    input  wire logic [irpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [irpd_pkg::THRESH_WIDTH-1:0]    cfg_data,
    output int                                        mismatches,
    output int                                        symbols_pending
);

    import irpd_pkg::*;

    logic [THRESH_WIDTH-1:0] gap_ticks;
    logic [THRESH_WIDTH-1:0] first_ticks;
    logic [THRESH_WIDTH-1:0] second_ticks;
    logic [PHASE_WIDTH-1:0]  dec_phase;
    logic [COUNT_WIDTH-1:0]  dec_count;
    logic [SYM_WIDTH-1:0]    expected_symbols[$];

    initial
    begin
        mismatches = 0;
        symbols_pending = 0;
    end

    // saturating count; a full counter always ends the delay
    function automatic logic delay_over(input logic [THRESH_WIDTH-1:0] limit);
        if (dec_count != '1)
            dec_count = dec_count + 1'b1;
        return (dec_count >= limit) || (dec_count == '1);
    endfunction

    task automatic step_decoder(input logic level, output logic produced,
                                output logic [SYM_WIDTH-1:0] sym);
        produced = 1'b0;
        sym = SYM_ZERO;
        case (dec_phase)
            PH_LEADER:
            begin
                if (level)
                begin
                    dec_count = '0;
                    dec_phase = PH_GAP;
                end
            end
            PH_GAP:
            begin
                // the sample that ends the gap also feeds the wait for high
                if (delay_over(gap_ticks))
                begin
                    dec_phase = PH_WAITHI;
                    if (level)
                    begin
                        dec_count = '0;
                        dec_phase = PH_FIRST;
                    end
                end
            end
            PH_WAITHI:
            begin
                if (level)
                begin
                    dec_count = '0;
                    dec_phase = PH_FIRST;
                end
            end
            PH_FIRST:
            begin
                if (delay_over(first_ticks))
                begin
                    if (!level)
                    begin
                        dec_phase = PH_WAITHI;
                        produced = 1'b1;
                        sym = SYM_ZERO;
                    end
                    else
                    begin
                        dec_count = '0;
                        dec_phase = PH_SECOND;
                    end
                end
            end
            PH_SECOND:
            begin
                if (delay_over(second_ticks))
                begin
                    produced = 1'b1;
                    if (!level)
                    begin
                        dec_phase = PH_WAITHI;
                        sym = SYM_ONE;
                    end
                    else
                    begin
                        dec_phase = PH_IDLE;
                        dec_count = '0;
                        sym = SYM_END;
                    end
                end
            end
            default:
            begin
                dec_phase = PH_IDLE;
                if (!level)
                begin
                    dec_count = '0;
                    dec_phase = PH_LEADER;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic                 produced;
        logic [SYM_WIDTH-1:0] sym;
        logic [SYM_WIDTH-1:0] want;
        if (!rst_n)
        begin
            gap_ticks = LEADER_GAP_RESET;
            first_ticks = FIRST_SAMPLE_RESET;
            second_ticks = SECOND_SAMPLE_RESET;
            dec_phase = PH_IDLE;
            dec_count = '0;
            expected_symbols.delete();
            symbols_pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_symbols.size() == 0)
                begin
                    $error("unexpected symbol transaction: symbol actual %0d", m_tdata[1:0]);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    if (m_tdata[SYM_WIDTH-1:0] !== want)
                    begin
                        $error("symbol mismatch: expected %0d actual %0d",
                               want, m_tdata[SYM_WIDTH-1:0]);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LEADER_GAP:    gap_ticks = cfg_data;
                    REG_FIRST_SAMPLE:  first_ticks = cfg_data;
                    REG_SECOND_SAMPLE: second_ticks = cfg_data;
                    default:           ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                step_decoder(s_tdata[0], produced, sym);
                if (produced)
                    expected_symbols.push_back(sym);
            end
            symbols_pending <= expected_symbols.size();
        end
    end

endmodule

### sim/tb.sv
// Top of the IR pulse-distance decoder testbench: clock, reset, line-sample
// stimulus, output back-pressure and the final verdict.
// Depends on irpd_pkg, ir_pulse_distance_bit_decoder and irpd_checker.
`timescale 1ns / 1ps

module tb;

    import irpd_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
    // time order left to right: leader, bit zero, bit one, end of frame
    localparam logic [15:0] DIRECTED_LEVELS = 16'b1001_1100_1110_1111;
    localparam int SAMPLES_PER_PHASE = 70;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [7:0]                 m_tdata;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [THRESH_WIDTH-1:0]    cfg_data = '0;
    int                         mismatches;
    int                         symbols_pending;

    int unsigned burst_left = 0;
    int unsigned ready_hold = 0;
    int unsigned samples_sent = 0;
    bit          steady = 1'b0;
    int unsigned cur_gap = 32'(LEADER_GAP_RESET);
    int unsigned cur_first = 32'(FIRST_SAMPLE_RESET);
    int unsigned cur_second = 32'(SECOND_SAMPLE_RESET);

    ir_pulse_distance_bit_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    irpd_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .symbols_pending (symbols_pending)
    );

    always #5 clk = ~clk;

    // symbol sink: short and long ready runs and stalls
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            m_tready <= !m_tready;
            if (m_tready)
                ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                          : $urandom_range(1, 3);
            else
                ready_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                          : $urandom_range(1, 12);
        end
        else
        begin
            ready_hold = ready_hold - 1;
        end
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned effective_ticks(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    task automatic send_sample(input logic level);
        logic [6:0]  pad;
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        pad = 7'($urandom);
        s_tvalid <= 1'b1;
        s_tdata <= {pad, level};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        burst_left = burst_left - 1;
        samples_sent = samples_sent + 1;
    endtask

    task automatic send_run(input logic level, input int unsigned count);
        repeat (count) send_sample(level);
    endtask

    task automatic pause_for_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (symbols_pending == 0);
        @(posedge clk);
    endtask

    // a long high stretch ends a frame from any phase
    task automatic drain_to_idle();
        send_run(1'b1, effective_ticks(cur_gap) + effective_ticks(cur_first) +
                       effective_ticks(cur_second) + 4);
        pause_for_results();
        repeat (4) @(posedge clk);
    endtask

    task automatic write_delays(input logic [15:0] gap, input logic [15:0] first,
                                input logic [15:0] second);
        logic [15:0] junk;
        junk = 16'($urandom);
        cfg_we <= 1'b1;
        cfg_index <= REG_LEADER_GAP;
        cfg_data <= gap;
        @(posedge clk);
        cfg_index <= REG_FIRST_SAMPLE;
        cfg_data <= first;
        @(posedge clk);
        cfg_index <= REG_SECOND_SAMPLE;
        cfg_data <= second;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data <= junk;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_gap = 32'(gap);
        cur_first = 32'(first);
        cur_second = 32'(second);
    endtask

    task automatic send_frame();
        int unsigned f;
        int unsigned s;
        int unsigned nbits;
        int unsigned kind;
        f = effective_ticks(cur_first);
        s = effective_ticks(cur_second);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 20)) send_sample(1'($urandom_range(0, 1)));
            return;
        end
        send_run(1'b0, $urandom_range(1, 5));
        send_run(1'b1, effective_ticks(cur_gap) + $urandom_range(0, f + 1));
        nbits = $urandom_range(1, 10);
        for (int b = 0; b < nbits; b++)
        begin
            send_run(1'b0, $urandom_range(1, 3));
            kind = $urandom_range(0, 2);
            if (kind == 0)
                send_run(1'b1, $urandom_range(1, f + 1));
            else if (kind == 1)
                send_run(1'b1, $urandom_range(f, f + s + 1));
            else
                break;
        end
        // cut-off frames are left for the next leader or the drain
        if ($urandom_range(0, 7) != 0)
        begin
            send_run(1'b0, $urandom_range(1, 3));
            send_run(1'b1, f + s + $urandom_range(1, 3));
        end
    endtask

    initial
    begin
        int unsigned frames;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_delays(16'd0, 16'd2, 16'd0);
        for (int i = 15; i >= 0; i--)
            send_sample(DIRECTED_LEVELS[i]);
        drain_to_idle();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                write_delays(16'd0, 16'd0, 16'd0);
            else if (p == 1)
                write_delays(16'd1, 16'd1, 16'd1);
            else
                write_delays(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                             16'($urandom_range(0, 12)));
            samples_sent = 0;
            frames = 0;
            while (samples_sent < SAMPLES_PER_PHASE)
            begin
                send_frame();
                frames = frames + 1;
                if (frames == 2 || $urandom_range(0, 15) == 0)
                    pause_for_results();
            end
            drain_to_idle();
        end

        // widest delays: a leader and the start of a long gap
        steady = 1'b1;
        write_delays(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_run(1'b0, 3);
        send_run(1'b1, 40);
        pause_for_results();
        steady = 1'b0;

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/irpd_pkg.sv
rtl/core/irpd_cfg_regs.sv
rtl/core/irpd_fsm.sv
rtl/core/irpd_out_queue.sv
rtl/core/ir_pulse_distance_bit_decoder.sv
sim/irpd_checker.sv
sim/tb.sv
